[design/binary_matrix_canonicalizer_top_macros.svh]
// assertion macros for the canonicalizer, used by the queue module
`ifndef BINARY_MATRIX_CANONICALIZER_TOP_MACROS_SVH
`define BINARY_MATRIX_CANONICALIZER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmc assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define BMC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmc assertion failed");

`endif

[design/bmc_pkg.sv]
// shared types, widths and the column permutation table for the canonicalizer
package bmc_pkg;

    localparam int KEY_W = 32;
    localparam int SGL_W = 3;
    localparam int MAX_COLS = 4;
    localparam int COL_IDX_W = 2;

    typedef struct packed {
        logic [KEY_W-1:0] mat;
        logic [SGL_W-1:0] sgl;
    } t_item;

    function automatic int perm_count(input int ncol);
        int n;
        n = 1;
        for (int i = 2; i <= ncol; i++) n = n * i;
        return n;
    endfunction

    // column taken into output position pos by the idx-th permutation,
    // permutations listed in order of their packed two-bit digit codes
    function automatic logic [COL_IDX_W-1:0] perm_col(input int ncol, input int idx,
                                                     input int pos);
        int seen;
        int dig [MAX_COLS];
        bit ok;
        logic [COL_IDX_W-1:0] res;
        seen = 0;
        res = '0;
        for (int code = 0; code < (1 << (COL_IDX_W * ncol)); code++) begin
            ok = 1'b1;
            for (int o = 0; o < MAX_COLS; o++) begin
                dig[o] = (code >> (COL_IDX_W * o)) & ((1 << COL_IDX_W) - 1);
                if (o < ncol && dig[o] >= ncol) ok = 1'b0;
            end
            for (int a = 0; a < ncol; a++)
                for (int b = a + 1; b < ncol; b++)
                    if (dig[a] == dig[b]) ok = 1'b0;
            if (ok) begin
                if (seen == idx) res = COL_IDX_W'(dig[pos]);
                seen = seen + 1;
            end
        end
        return res;
    endfunction

endpackage

[design/bmc_ifs.sv]
// valid/ready channel interfaces for the key beats and the result beats
interface bmc_in_if;
    import bmc_pkg::*;
    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] key;
    logic             complement;
    modport source (output valid, func, key, complement, input ready);
    modport sink (input valid, func, key, complement, output ready);
endinterface

interface bmc_out_if;
    import bmc_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] canonical_key;
    logic [SGL_W-1:0] sgl_count;
    modport source (output valid, canonical_key, sgl_count, input ready);
    modport sink (input valid, canonical_key, sgl_count, output ready);
endinterface

[design/bmc_front.sv]
// front stage: complement, then sparse column stripping and singleton count when func is set
module bmc_front
    import bmc_pkg::*;
#(
    parameter int ROW_COUNT = 8,
    parameter int COLUMN_COUNT = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmc_in_if.sink       i_in,
    output logic         o_valid,
    output t_item        o_item,
    input  logic         i_ready
);
    localparam int USED_W = ROW_COUNT * COLUMN_COUNT;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [USED_W-1:0] mat;
    logic [SGL_W-1:0]  sgl;
    logic              seen;
    logic              multi;

    assign i_in.ready = !r_valid || i_ready;

    always_comb begin
        mat = i_in.key[USED_W-1:0] ^ {USED_W{i_in.complement}};
        sgl = '0;
        seen = 1'b0;
        multi = 1'b0;
        if (i_in.func) begin
            for (int c = 0; c < COLUMN_COUNT; c++) begin
                seen = 1'b0;
                multi = 1'b0;
                for (int r = 0; r < ROW_COUNT; r++) begin
                    if (mat[r * COLUMN_COUNT + c]) begin
                        multi = multi | seen;
                        seen = 1'b1;
                    end
                end
                // a column with at most one set bit is cleared
                if (!multi) begin
                    if (seen) sgl = sgl + SGL_W'(1);
                    for (int r = 0; r < ROW_COUNT; r++) mat[r * COLUMN_COUNT + c] = 1'b0;
                end
            end
        end
        n_item.mat = KEY_W'(mat);
        n_item.sgl = sgl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

[design/bmc_queue.sv]
// two-entry queue between the front stage and the permutation pipeline
module bmc_queue
    import bmc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);
    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    `include "binary_matrix_canonicalizer_top_macros.svh"

    `BMC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= 2'd2)
    `BMC_ASSERT_NOW(a_ptr_match, r_count == 2'd0 || r_count == 2'd2, r_wp == r_rp)
    `BMC_ASSERT_NXT(a_fill_up, push && !pop, r_count == $past(r_count) + 2'd1)
endmodule

[design/bmc_back.sv]
// back end: one lane per column permutation, row sort, registered minimum tree
module bmc_back
    import bmc_pkg::*;
#(
    parameter int ROW_COUNT = 8,
    parameter int COLUMN_COUNT = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_ready,
    bmc_out_if.source o_out
);
    localparam int USED_W = ROW_COUNT * COLUMN_COUNT;
    localparam int NPERM  = perm_count(COLUMN_COUNT);
    localparam int LEVELS = (NPERM > 1) ? $clog2(NPERM) : 1;
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;

    logic             en;
    logic [KEY_W-1:0] r_node [NODES];
    logic             r_vld  [LEVELS+1];
    logic [SGL_W-1:0] r_sgl  [LEVELS+1];

    // whole pipeline moves together unless the output beat is stuck
    assign en      = !r_vld[LEVELS] || o_out.ready;
    assign o_ready = en;

    for (genvar p = 0; p < LEAVES; p++) begin : g_lane
        if (p < NPERM) begin : g_real
            logic [COLUMN_COUNT-1:0] t [ROW_COUNT];
            logic [COLUMN_COUNT-1:0] tmp;
            logic [USED_W-1:0]       cand;

            always_comb begin
                tmp = '0;
                for (int r = 0; r < ROW_COUNT; r++)
                    for (int o = 0; o < COLUMN_COUNT; o++)
                        t[r][o] = i_item.mat[(ROW_COUNT - 1 - r) * COLUMN_COUNT
                                             + int'(perm_col(COLUMN_COUNT, p, o))];
                // odd-even transposition sort, ascending
                for (int s = 0; s < ROW_COUNT; s++)
                    for (int r = s % 2; r + 1 < ROW_COUNT; r += 2)
                        if (t[r] > t[r+1]) begin
                            tmp    = t[r];
                            t[r]   = t[r+1];
                            t[r+1] = tmp;
                        end
                for (int r = 0; r < ROW_COUNT; r++)
                    cand[(ROW_COUNT - 1 - r) * COLUMN_COUNT +: COLUMN_COUNT] = t[r];
            end

            always_ff @(posedge i_clk) begin
                if (en) r_node[LEAVES - 1 + p] <= KEY_W'(cand);
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                if (en) r_node[LEAVES - 1 + p] <= '1;
            end
        end
    end

    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_tree
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_node[n] <= (r_node[2*n+2] < r_node[2*n+1]) ? r_node[2*n+2] : r_node[2*n+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LEVELS; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= LEVELS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sgl[0] <= i_item.sgl;
            for (int k = 1; k <= LEVELS; k++) r_sgl[k] <= r_sgl[k-1];
        end
    end

    assign o_out.valid         = r_vld[LEVELS];
    assign o_out.canonical_key = r_node[0];
    assign o_out.sgl_count     = r_sgl[LEVELS];
endmodule

[design/binary_matrix_canonicalizer_top.sv]
// Canonical form of a ROW_COUNT x COLUMN_COUNT 0/1 matrix under column permutation and
// row reordering. Takes one key beat per cycle while result beats are taken, and returns one
// result beat per key, in order. From input beat to result beat a key passes one front
// register (complement, sparse column strip), one queue slot, one lane register per
// permutation, and a registered pairwise minimum tree over the permutation lanes (5 levels
// at 4 columns); an output stall holds the lanes and the tree. A two-entry queue separates
// the front from the pipeline so an output stall does not block the next key immediately.
// Key bits above the matrix are ignored and read back as zero.
module binary_matrix_canonicalizer_top
    import bmc_pkg::*;
#(
    parameter int ROW_COUNT = 8,
    parameter int COLUMN_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmc_in_if.sink    i_in,
    bmc_out_if.source o_out
);
    logic  f_valid;
    t_item f_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  b_ready;

    bmc_front #(.ROW_COUNT(ROW_COUNT), .COLUMN_COUNT(COLUMN_COUNT)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_ready (q_ready)
    );

    bmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (b_ready)
    );

    bmc_back #(.ROW_COUNT(ROW_COUNT), .COLUMN_COUNT(COLUMN_COUNT)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_ready (b_ready),
        .o_out   (o_out)
    );
endmodule

[tb/bmc_scoreboard.sv]
// result checker for the canonicalizer: predicts each key beat and compares result beats
`timescale 1ns / 1ps
module bmc_scoreboard
    import bmc_pkg::*;
#(
    parameter int ROW_COUNT = 8,
    parameter int COLUMN_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmc_in_if         i_in,
    bmc_out_if        i_out,
    output int        o_errors,
    output int        o_results
);

    localparam logic [3:0] ROW_MASK = 4'((1 << COLUMN_COUNT) - 1);

    t_item canon_q[$];
    int    mismatches;

    // minimum packed sorted-row form over every column ordering
    function automatic logic [KEY_W-1:0] min_over_orders(input logic [3:0] rows[8]);
        logic [KEY_W-1:0] best;
        logic [KEY_W-1:0] cand;
        logic [3:0]       t[8];
        logic [3:0]       v;
        int               ord[4];
        int               n;
        int               c;
        int               b;
        bit               dup;
        best = '1;
        n = 1;
        for (int i = 0; i < COLUMN_COUNT; i++) n = n * COLUMN_COUNT;
        for (int code = 0; code < n; code++) begin
            c = code;
            for (int o = 0; o < COLUMN_COUNT; o++) begin
                ord[o] = c % COLUMN_COUNT;
                c = c / COLUMN_COUNT;
            end
            dup = 1'b0;
            for (int a = 0; a < COLUMN_COUNT; a++)
                for (int k = a + 1; k < COLUMN_COUNT; k++)
                    if (ord[a] == ord[k]) dup = 1'b1;
            if (!dup) begin
                for (int r = 0; r < ROW_COUNT; r++) begin
                    t[r] = '0;
                    for (int o = 0; o < COLUMN_COUNT; o++) t[r][o] = rows[r][ord[o]];
                end
                for (int a = 1; a < ROW_COUNT; a++) begin
                    v = t[a];
                    b = a;
                    while (b > 0 && t[b-1] > v) begin
                        t[b] = t[b-1];
                        b--;
                    end
                    t[b] = v;
                end
                cand = '0;
                for (int r = 0; r < ROW_COUNT; r++) cand = (cand << COLUMN_COUNT) | KEY_W'(t[r]);
                if (cand < best) best = cand;
            end
        end
        return best;
    endfunction

    function automatic t_item canonicalize(input logic func, input logic [KEY_W-1:0] key,
                                           input logic comp);
        logic [3:0] rows[8];
        int         ones;
        t_item      res;
        res.sgl = '0;
        for (int r = 0; r < 8; r++) rows[r] = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            rows[r] = 4'(key >> (COLUMN_COUNT * (ROW_COUNT - 1 - r))) & ROW_MASK;
            if (comp) rows[r] = rows[r] ^ ROW_MASK;
        end
        if (func) begin
            for (int c = 0; c < COLUMN_COUNT; c++) begin
                ones = 0;
                for (int r = 0; r < ROW_COUNT; r++) ones += rows[r][c];
                if (ones <= 1) begin
                    if (ones == 1) res.sgl = res.sgl + 1'b1;
                    for (int r = 0; r < ROW_COUNT; r++) rows[r][c] = 1'b0;
                end
            end
        end
        res.mat = min_over_orders(rows);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_item want;
        if (!i_rst_n) begin
            canon_q.delete();
            mismatches <= 0;
            o_results <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                canon_q = {canon_q, canonicalize(i_in.func, i_in.key, i_in.complement)};
            if (i_out.valid && i_out.ready) begin
                o_results <= o_results + 1;
                if (canon_q.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result beat %h/%0d",
                        i_out.canonical_key, i_out.sgl_count);
                    mismatches <= mismatches + 1;
                end else begin
                    want = canon_q.pop_front();
                    if (want.mat !== i_out.canonical_key || want.sgl !== i_out.sgl_count) begin
                        if (mismatches < 10)
                            $display("mismatch: expected key %h sgl %0d, got key %h sgl %0d",
                                want.mat, want.sgl, i_out.canonical_key, i_out.sgl_count);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    assign o_errors = mismatches + canon_q.size();

endmodule

[tb/tb_binary_matrix_canonicalizer_top.sv]
// stimulus and verdict for the canonicalizer top level
`timescale 1ns / 1ps
module tb_binary_matrix_canonicalizer_top;
    import bmc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   results;
    int   sent;
    int   send_idle;
    int   sink_stall;
    int   hold_off;
    int   quiet;
    logic [KEY_W-1:0] next_key;

    bmc_in_if  in_ch();
    bmc_out_if out_ch();

    binary_matrix_canonicalizer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    bmc_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_errors(errors), .o_results(results)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.key = '0;
        in_ch.complement = 1'b0;
        out_ch.ready = 1'b0;
        sink_stall = 0;
        hold_off = 0;
    end

    // receiver: random stalls per phase, plus one long hold-off in the last phase
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    // offer one beat and wait until it is taken, idling at random first
    task automatic send_beat(input logic func, input logic [KEY_W-1:0] key, input logic comp);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= func;
        in_ch.key <= key;
        in_ch.complement <= comp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic random_beat();
        case ($urandom_range(3))
            0: next_key = $urandom();
            // sparse matrices hit the column stripping
            1: next_key = $urandom() & $urandom() & $urandom();
            2: next_key = ~($urandom() & $urandom() & $urandom());
            default: next_key = 32'h1 << $urandom_range(31);
        endcase
        send_beat(1'($urandom_range(1)), next_key, 1'($urandom_range(1)));
    endtask

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("FAIL binary_matrix_canonicalizer_top");
            $finish;
        end
    end

    initial begin
        sent = 0;
        quiet = 0;
        send_idle = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, both modes, complement, lone bits and single columns
        for (int f = 0; f < 2; f++)
            for (int c = 0; c < 2; c++) begin
                send_beat(1'(f), 32'h0000_0000, 1'(c));
                send_beat(1'(f), 32'hFFFF_FFFF, 1'(c));
                send_beat(1'(f), 32'h8000_0001, 1'(c));
            end
        send_beat(1'b1, 32'h1111_1111, 1'b0);
        send_beat(1'b1, 32'h1000_0000, 1'b0);
        send_beat(1'b1, 32'h1248_0000, 1'b0);
        send_beat(1'b1, 32'h3300_0000, 1'b0);
        send_beat(1'b1, 32'hEFFF_FFFF, 1'b1);
        send_beat(1'b0, 32'h1234_5678, 1'b0);
        send_beat(1'b0, 32'hA5A5_5A5A, 1'b1);
        send_beat(1'b1, 32'hF000_0001, 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  sink_stall = 0;  end
                1: begin send_idle = 76; sink_stall = 0;  end
                2: begin send_idle = 0;  sink_stall = 76; end
                3: begin send_idle = 22; sink_stall = 22; end
                default: begin send_idle = 0; sink_stall = 0; end
            endcase
            if (ph == 4) hold_off <= 200;
            for (int n = 0; n < 240; n++) random_beat();
        end
        in_ch.valid <= 1'b0;
        sink_stall = 0;

        while (results < sent) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("covered %0d key beats in both modes with and without complement", sent);
        $display("idle and stall phases plus one long output hold-off");
        if (errors == 0 && results == sent)
            $display("PASS binary_matrix_canonicalizer_top");
        else
            $display("FAIL binary_matrix_canonicalizer_top");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/bmc_pkg.sv
design/bmc_ifs.sv
design/bmc_front.sv
design/bmc_queue.sv
design/bmc_back.sv
design/binary_matrix_canonicalizer_top.sv
tb/bmc_scoreboard.sv
tb/tb_binary_matrix_canonicalizer_top.sv
